// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked property, disabled while reset is asserted
`define PVD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// same with a caller supplied message
`define PVD_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`else
`define PVD_ASSERT(lbl, clk, rst_n, prop)
`define PVD_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ===== rtl/pvd_pkg.sv =====
// types, constants and helper functions of the polynomial evaluator
`default_nettype none

package pvd_pkg;

  localparam int NUM_COEFS      = 6;
  localparam int DATA_W         = 32;
  localparam int WIDE_W         = 64;
  localparam int DEG_W          = 3;
  localparam int LVL_W          = $clog2(NUM_COEFS);
  localparam int CFG_IDX_W      = 3;
  localparam int SCALE_W        = 5;
  localparam int MAX_DEGREE_DEF = 5;
  localparam int FRAC_BITS_DEF  = 16;
  localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST  = 3'd6;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // one multiply per operation: next power, or a term of p, p' or p''
  typedef enum logic [1:0] {
    OP_POW,
    OP_POS,
    OP_VEL,
    OP_ACC
  } op_e;

  typedef struct packed {
    logic             start;
    logic             issue;
    op_e              op;
    logic [LVL_W-1:0] level;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } stat_t;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  // clamp a wide value to the signed 32-bit range
  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    r.sat = 1'b0;
    r.val = v[DATA_W-1:0];
    if (v > SAT_MAX) begin
      r.sat = 1'b1;
      r.val = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r.sat = 1'b1;
      r.val = SAT_MIN[DATA_W-1:0];
    end
    return r;
  endfunction

  // derivative weight of a term: k for p', k(k-1) for p''
  function automatic logic [SCALE_W-1:0] term_scale(input op_e op,
                                                    input logic [LVL_W-1:0] lvl);
    logic [SCALE_W-1:0] k1;
    logic [SCALE_W-1:0] k2;
    logic [SCALE_W-1:0] r;
    k1 = SCALE_W'(lvl) + 5'd1;
    k2 = k1 + 5'd1;
    case (op)
      OP_VEL:  r = k1;
      OP_ACC:  r = SCALE_W'(k1 * k2);
      default: r = 5'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pvd_cfg.sv =====
// configuration registers: degree in use and the six coefficients
`default_nettype none

module pvd_cfg (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic [pvd_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [pvd_pkg::DATA_W-1:0]             cfg_data_i,
  output logic [pvd_pkg::DEG_W-1:0]              degree_o,
  output logic signed [pvd_pkg::DATA_W-1:0]      coef_o [pvd_pkg::NUM_COEFS]
);

  logic [pvd_pkg::DEG_W-1:0]         degree_q;
  logic signed [pvd_pkg::DATA_W-1:0] coef_q [pvd_pkg::NUM_COEFS];
  logic [pvd_pkg::LVL_W-1:0]         coef_sel;

  assign coef_sel = pvd_pkg::LVL_W'(cfg_index_i - pvd_pkg::REG_COEF_FIRST);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= pvd_pkg::DEGREE_RESET;
      for (int i = 0; i < pvd_pkg::NUM_COEFS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pvd_pkg::REG_DEGREE: begin
          degree_q <= cfg_data_i[pvd_pkg::DEG_W-1:0];
        end
        default: begin
          if (cfg_index_i >= pvd_pkg::REG_COEF_FIRST &&
              cfg_index_i <= pvd_pkg::REG_COEF_LAST) begin
            coef_q[coef_sel] <= cfg_data_i;
          end
        end
      endcase
    end
  end

  assign degree_o = degree_q;
  assign coef_o   = coef_q;

endmodule

`default_nettype wire

// ===== rtl/pvd_ctrl.sv =====
// controller: sequences powers and term multiplies for one item
`default_nettype none
`include "assert_macros.svh"

module pvd_ctrl #(
  parameter int MAX_DEGREE = pvd_pkg::MAX_DEGREE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pvd_pkg::DEG_W-1:0] degree_i,
  input  pvd_pkg::stat_t            stat_i,
  output pvd_pkg::cmd_t             cmd_o
);

  localparam int CAP_INT = (MAX_DEGREE < pvd_pkg::NUM_COEFS - 1) ?
                           MAX_DEGREE : pvd_pkg::NUM_COEFS - 1;
  localparam logic [pvd_pkg::LVL_W-1:0] CAP = pvd_pkg::LVL_W'(CAP_INT);

  pvd_pkg::state_e           state_q, state_d;
  pvd_pkg::op_e              op_q, op_d;
  logic [pvd_pkg::LVL_W-1:0] level_q, level_d;
  logic [pvd_pkg::LVL_W-1:0] deg_eff;
  logic [pvd_pkg::LVL_W-1:0] nl_level;
  pvd_pkg::op_e              nl_op;

  // effective degree
  assign deg_eff = (pvd_pkg::LVL_W'(degree_i) > CAP) ? CAP : pvd_pkg::LVL_W'(degree_i);

  // first operation of the next power level
  assign nl_level = level_q + 3'd1;
  assign nl_op    = (nl_level < deg_eff) ? pvd_pkg::OP_POW : pvd_pkg::OP_POS;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pvd_pkg::ST_IDLE;
      op_q    <= pvd_pkg::OP_POW;
      level_q <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      level_q <= level_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    level_d    = level_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      pvd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = pvd_pkg::ST_RUN;
          level_d     = '0;
          op_d        = (deg_eff != '0) ? pvd_pkg::OP_POW : pvd_pkg::OP_POS;
        end
      end
      pvd_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = op_q;
        cmd_o.level = level_q;
        unique case (op_q)
          pvd_pkg::OP_POW: begin
            op_d = pvd_pkg::OP_POS;
          end
          pvd_pkg::OP_POS: begin
            if (level_q < deg_eff) begin
              op_d = pvd_pkg::OP_VEL;
            end else begin
              state_d = pvd_pkg::ST_DRAIN;
            end
          end
          pvd_pkg::OP_VEL: begin
            if ({1'b0, level_q} + 4'd2 <= {1'b0, deg_eff}) begin
              op_d = pvd_pkg::OP_ACC;
            end else begin
              op_d    = nl_op;
              level_d = nl_level;
            end
          end
          pvd_pkg::OP_ACC: begin
            op_d    = nl_op;
            level_d = nl_level;
          end
          default: begin
            state_d = pvd_pkg::ST_IDLE;
          end
        endcase
      end
      pvd_pkg::ST_DRAIN: begin
        state_d = pvd_pkg::ST_FINISH;
      end
      pvd_pkg::ST_FINISH: begin
        if (!stat_i.out_blocked) begin
          cmd_o.finish = 1'b1;
          state_d      = pvd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pvd_pkg::ST_IDLE;
      end
    endcase
  end

  // schedule checks
  `PVD_ASSERT(a_level_in_range, clk_i, rst_ni, cmd_o.issue |-> cmd_o.level <= deg_eff)
  `PVD_ASSERT_MSG(a_pow_below_deg, clk_i, rst_ni, (cmd_o.issue && cmd_o.op == pvd_pkg::OP_POW) |-> cmd_o.level < deg_eff, "power step beyond degree")
  `PVD_ASSERT(a_start_then_issue, clk_i, rst_ni, cmd_o.start |=> cmd_o.issue)

endmodule

`default_nettype wire

// ===== rtl/pvd_dp.sv =====
// datapath: shared multiplier, power registers, accumulators, output register
`default_nettype none
`include "assert_macros.svh"

module pvd_dp #(
  parameter int FRAC_BITS = pvd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pvd_pkg::cmd_t                     cmd_i,
  output pvd_pkg::stat_t                    stat_o,
  input  logic signed [pvd_pkg::DATA_W-1:0] sample_point_i,
  input  logic signed [pvd_pkg::DATA_W-1:0] coef_i [pvd_pkg::NUM_COEFS],
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [pvd_pkg::DATA_W-1:0] position_o,
  output logic signed [pvd_pkg::DATA_W-1:0] velocity_o,
  output logic signed [pvd_pkg::DATA_W-1:0] acceleration_o,
  output logic                              overflow_o
);

  localparam logic signed [pvd_pkg::DATA_W-1:0] W_ONE = 32'sd1 <<< FRAC_BITS;

  logic signed [pvd_pkg::DATA_W-1:0] x_q;
  logic signed [pvd_pkg::DATA_W-1:0] pw_q [pvd_pkg::NUM_COEFS];
  logic [pvd_pkg::NUM_COEFS-1:0]     pm_q;

  logic signed [pvd_pkg::WIDE_W-1:0] prod_q;
  logic                              s2_valid_q;
  pvd_pkg::op_e                      s2_op_q;
  logic [pvd_pkg::LVL_W-1:0]         s2_lvl_q;
  logic                              s2_pm_q;
  logic                              s2_nz_q;

  logic signed [pvd_pkg::WIDE_W-1:0] p_q, v_q, a_q;
  logic                              ovf_q;

  logic                              out_valid_q;
  logic signed [pvd_pkg::DATA_W-1:0] pos_q, vel_q, acc_q;
  logic                              oflag_q;

  logic [pvd_pkg::LVL_W-1:0]         coef_off;
  logic [pvd_pkg::LVL_W-1:0]         cidx;
  logic signed [pvd_pkg::DATA_W-1:0] op_a, op_b;
  logic signed [pvd_pkg::WIDE_W-1:0] prod_d;

  logic signed [pvd_pkg::WIDE_W-1:0] sh;
  pvd_pkg::sat_t                     pw_sat;
  logic [pvd_pkg::SCALE_W-1:0]       scale;
  logic signed [pvd_pkg::WIDE_W-1:0] term;
  logic [pvd_pkg::LVL_W-1:0]         wr_idx;

  pvd_pkg::sat_t                     p_sat, v_sat, a_sat;

  // operand select for the multiplier
  always_comb begin
    case (cmd_i.op)
      pvd_pkg::OP_VEL: coef_off = 3'd1;
      pvd_pkg::OP_ACC: coef_off = 3'd2;
      default:         coef_off = 3'd0;
    endcase
  end

  assign cidx   = cmd_i.level + coef_off;
  assign op_a   = (cmd_i.op == pvd_pkg::OP_POW) ? x_q : coef_i[cidx];
  assign op_b   = pw_q[cmd_i.level];
  assign prod_d = op_a * op_b;

  // floor shift, power clamp and derivative weighting
  assign sh     = prod_q >>> FRAC_BITS;
  assign pw_sat = pvd_pkg::sat32(sh);
  assign scale  = pvd_pkg::term_scale(s2_op_q, s2_lvl_q);
  assign term   = pvd_pkg::WIDE_W'(sh * $signed({1'b0, scale}));
  assign wr_idx = s2_lvl_q + 3'd1;

  // final clamp of the three sums
  assign p_sat = pvd_pkg::sat32(p_q);
  assign v_sat = pvd_pkg::sat32(v_q);
  assign a_sat = pvd_pkg::sat32(a_q);

  // pipeline and output valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= cmd_i.issue;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q     <= sample_point_i;
      pw_q[0] <= W_ONE;
      pm_q[0] <= 1'b0;
      p_q     <= '0;
      v_q     <= '0;
      a_q     <= '0;
      ovf_q   <= 1'b0;
    end
    if (cmd_i.issue) begin
      prod_q   <= prod_d;
      s2_op_q  <= cmd_i.op;
      s2_lvl_q <= cmd_i.level;
      s2_pm_q  <= pm_q[cmd_i.level];
      s2_nz_q  <= (op_a != '0);
    end
    if (s2_valid_q) begin
      case (s2_op_q)
        pvd_pkg::OP_POW: begin
          pw_q[wr_idx] <= pw_sat.val;
          pm_q[wr_idx] <= s2_pm_q | pw_sat.sat;
        end
        pvd_pkg::OP_POS: p_q <= p_q + term;
        pvd_pkg::OP_VEL: v_q <= v_q + term;
        default:         a_q <= a_q + term;
      endcase
      if (s2_op_q != pvd_pkg::OP_POW) begin
        ovf_q <= ovf_q | (s2_pm_q & s2_nz_q);
      end
    end
    if (cmd_i.finish) begin
      pos_q   <= p_sat.val;
      vel_q   <= v_sat.val;
      acc_q   <= a_sat.val;
      oflag_q <= ovf_q | p_sat.sat | v_sat.sat | a_sat.sat;
    end
  end

  assign stat_o.out_blocked = out_valid_q & ~out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign position_o     = pos_q;
  assign velocity_o     = vel_q;
  assign acceleration_o = acc_q;
  assign overflow_o     = oflag_q;

  // sequencing checks
  `PVD_ASSERT(a_finish_drained, clk_i, rst_ni, cmd_i.finish |-> !s2_valid_q)
  `PVD_ASSERT(a_start_drained, clk_i, rst_ni, cmd_i.start |-> !s2_valid_q)
  `PVD_ASSERT_MSG(a_out_from_finish, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_i.finish), "result without finish")

endmodule

`default_nettype wire

// ===== rtl/polynomial_value_and_derivatives.sv =====
// Items are taken one at a time: the next item is accepted only after the last one
// has finished, and finishing waits while the output register holds an untaken result.
// The single shared 32x32 multiplier takes the D powers and 3*D term products
// (one at D = 0) in turn, D the effective degree.
// Reset: degree in use returns to 5, coefficients to 0, no item pending.
// A finished result waits in the output register while the next item starts.
`default_nettype none

module polynomial_value_and_derivatives #(
  parameter int MAX_DEGREE = pvd_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = pvd_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pvd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pvd_pkg::DATA_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [pvd_pkg::DATA_W-1:0]    sample_point_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pvd_pkg::DATA_W-1:0]    position_o,
  output logic signed [pvd_pkg::DATA_W-1:0]    velocity_o,
  output logic signed [pvd_pkg::DATA_W-1:0]    acceleration_o,
  output logic                                 overflow_o
);

  logic [pvd_pkg::DEG_W-1:0]         degree;
  logic signed [pvd_pkg::DATA_W-1:0] coef [pvd_pkg::NUM_COEFS];
  pvd_pkg::cmd_t                     cmd;
  pvd_pkg::stat_t                    stat;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  // configuration registers
  pvd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .degree_o    (degree),
    .coef_o      (coef)
  );

  // sequencer
  pvd_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .degree_i   (degree),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic
  pvd_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .sample_point_i (sample_point_i),
    .coef_i         (coef),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .overflow_o     (overflow_o)
  );

endmodule

`default_nettype wire

// ===== test/polynomial_value_and_derivatives_tb.sv =====
// testbench of the polynomial evaluator: directed and random points checked against a predictor
module polynomial_value_and_derivatives_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DEG_LIMIT   = pvd_pkg::MAX_DEGREE_DEF;
  localparam int FRAC        = pvd_pkg::FRAC_BITS_DEF;
  localparam logic [pvd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = pvd_pkg::REG_COEF_LAST + 3'd1;
  localparam logic [pvd_pkg::DATA_W-1:0] ONE_Q    = 32'h0001_0000;
  localparam logic [pvd_pkg::DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [pvd_pkg::DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam longint LONG_MAX = 64'sd2147483647;
  localparam longint LONG_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [pvd_pkg::DATA_W-1:0] position;
    logic signed [pvd_pkg::DATA_W-1:0] velocity;
    logic signed [pvd_pkg::DATA_W-1:0] acceleration;
    logic                              overflow;
  } motion_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [pvd_pkg::CFG_IDX_W-1:0]     cfg_index_i;
  logic [pvd_pkg::DATA_W-1:0]        cfg_data_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic signed [pvd_pkg::DATA_W-1:0] sample_point_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic signed [pvd_pkg::DATA_W-1:0] position_o;
  logic signed [pvd_pkg::DATA_W-1:0] velocity_o;
  logic signed [pvd_pkg::DATA_W-1:0] acceleration_o;
  logic                              overflow_o;

  // mirror of the configuration registers
  logic [pvd_pkg::DEG_W-1:0]         degree_mirror;
  logic signed [pvd_pkg::DATA_W-1:0] coef_mirror [pvd_pkg::NUM_COEFS];

  motion_t expected_motion_q [$];
  int error_count     = 0;
  int results_checked = 0;
  int settings_count  = 0;
  int in_gap_max      = 9;
  int out_gap_max     = 9;
  int hold_off_cycles = 0;
  int cycle_count     = 0;

  polynomial_value_and_derivatives i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_point_i (sample_point_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .overflow_o     (overflow_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit exceeds_word(input longint v);
    return (v > LONG_MAX) || (v < LONG_MIN);
  endfunction

  function automatic longint clamp_word(input longint v);
    if (v > LONG_MAX) return LONG_MAX;
    if (v < LONG_MIN) return LONG_MIN;
    return v;
  endfunction

  // position, velocity and acceleration at one point, from the mirrored registers
  function automatic motion_t compute_motion(input logic signed [pvd_pkg::DATA_W-1:0] x);
    longint  pw [pvd_pkg::NUM_COEFS];
    bit      marked [pvd_pkg::NUM_COEFS];
    longint  pos;
    longint  vel;
    longint  acc;
    longint  c;
    longint  t;
    bit      ovf;
    int      d;
    motion_t m;
    d = int'(degree_mirror);
    if (d > DEG_LIMIT) d = DEG_LIMIT;
    if (d > pvd_pkg::NUM_COEFS - 1) d = pvd_pkg::NUM_COEFS - 1;
    pw[0] = longint'(1) <<< FRAC;
    marked[0] = 1'b0;
    // powers of x, clamped, with a sticky mark once one saturates
    for (int k = 1; k <= d; k++) begin
      t = (pw[k-1] * longint'(x)) >>> FRAC;
      pw[k] = clamp_word(t);
      marked[k] = marked[k-1] || exceeds_word(t);
    end
    pos = 0;
    vel = 0;
    acc = 0;
    ovf = 1'b0;
    for (int k = 0; k <= d; k++) begin
      c = longint'(coef_mirror[k]);
      pos += (c * pw[k]) >>> FRAC;
      if (marked[k] && c != 0) ovf = 1'b1;
      if (k >= 1) begin
        vel += longint'(k) * ((c * pw[k-1]) >>> FRAC);
        if (marked[k-1] && c != 0) ovf = 1'b1;
      end
      if (k >= 2) begin
        acc += longint'(k * (k - 1)) * ((c * pw[k-2]) >>> FRAC);
        if (marked[k-2] && c != 0) ovf = 1'b1;
      end
    end
    ovf = ovf | exceeds_word(pos) | exceeds_word(vel) | exceeds_word(acc);
    pos = clamp_word(pos);
    vel = clamp_word(vel);
    acc = clamp_word(acc);
    m.position     = pos[pvd_pkg::DATA_W-1:0];
    m.velocity     = vel[pvd_pkg::DATA_W-1:0];
    m.acceleration = acc[pvd_pkg::DATA_W-1:0];
    m.overflow     = ovf;
    return m;
  endfunction

  // mix of small, fractional, extreme and fully random coefficients
  function automatic logic [pvd_pkg::DATA_W-1:0] random_coef();
    logic [pvd_pkg::DATA_W-1:0] r;
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      2, 3: r = $urandom;
      default: r = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
    return r;
  endfunction

  // mostly points within four units of zero, where powers of x stay far from saturation
  function automatic logic [pvd_pkg::DATA_W-1:0] random_point();
    logic [pvd_pkg::DATA_W-1:0] r;
    case ($urandom_range(0, 9))
      0: r = '0;
      1: begin
        case ($urandom_range(0, 3))
          0: r = WORD_MAX;
          1: r = WORD_MIN;
          2: r = ONE_Q;
          default: r = -ONE_Q;
        endcase
      end
      2, 3: r = $urandom;
      4, 5, 6: r = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: r = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    endcase
    return r;
  endfunction

  // one configuration register write
  task automatic write_reg(input logic [pvd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pvd_pkg::DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == pvd_pkg::REG_DEGREE) begin
      degree_mirror = data[pvd_pkg::DEG_W-1:0];
    end else if (idx >= pvd_pkg::REG_COEF_FIRST && idx <= pvd_pkg::REG_COEF_LAST) begin
      coef_mirror[idx - pvd_pkg::REG_COEF_FIRST] = data;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all_coefs(input logic [pvd_pkg::DATA_W-1:0] c0,
                                 input logic [pvd_pkg::DATA_W-1:0] c1,
                                 input logic [pvd_pkg::DATA_W-1:0] c2,
                                 input logic [pvd_pkg::DATA_W-1:0] c3,
                                 input logic [pvd_pkg::DATA_W-1:0] c4,
                                 input logic [pvd_pkg::DATA_W-1:0] c5);
    write_reg(pvd_pkg::REG_COEF_FIRST + 3'd0, c0);
    write_reg(pvd_pkg::REG_COEF_FIRST + 3'd1, c1);
    write_reg(pvd_pkg::REG_COEF_FIRST + 3'd2, c2);
    write_reg(pvd_pkg::REG_COEF_FIRST + 3'd3, c3);
    write_reg(pvd_pkg::REG_COEF_FIRST + 3'd4, c4);
    write_reg(pvd_pkg::REG_COEF_FIRST + 3'd5, c5);
    settings_count++;
  endtask

  // offer one sample point and record what it should produce
  task automatic send_sample(input logic [pvd_pkg::DATA_W-1:0] x);
    int      gap;
    motion_t want;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    sample_point_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    want = compute_motion(x);
    expected_motion_q = {expected_motion_q, want};
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_motion_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side: random stalls, an optional long hold-off, field checks
  initial begin : result_checker
    int      stall;
    motion_t want;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (hold_off_cycles - 1) @(negedge clk_i);
        hold_off_cycles = 0;
      end
      stall = $urandom_range(0, out_gap_max);
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_motion_q.size() == 0) begin
        $error("result item with no sample point outstanding");
        error_count++;
      end else begin
        want = expected_motion_q.pop_front();
        results_checked++;
        if (position_o !== want.position) begin
          $error("position mismatch: expected %0d, got %0d", want.position, position_o);
          error_count++;
        end
        if (velocity_o !== want.velocity) begin
          $error("velocity mismatch: expected %0d, got %0d", want.velocity, velocity_o);
          error_count++;
        end
        if (acceleration_o !== want.acceleration) begin
          $error("acceleration mismatch: expected %0d, got %0d",
                 want.acceleration, acceleration_o);
          error_count++;
        end
        if (overflow_o !== want.overflow) begin
          $error("overflow mismatch: expected %0b, got %0b", want.overflow, overflow_o);
          error_count++;
        end
      end
    end
  end

  // zero coefficients after reset give zero everywhere
  task automatic test_reset_state();
    send_sample(WORD_MAX);
    send_sample(WORD_MIN);
    wait_idle();
  endtask

  // degrees 0, 1, 2, 5 and 7, including one above the supported range
  task automatic test_each_degree();
    logic [pvd_pkg::DEG_W-1:0] degs [5];
    degs = '{3'd0, 3'd1, 3'd2, 3'd5, 3'd7};
    write_all_coefs(ONE_Q, 32'hfffe_0000, 32'h0000_8000, 32'h0003_0000,
                    32'hfffe_8000, 32'h0000_4000);
    foreach (degs[i]) begin
      write_reg(pvd_pkg::REG_DEGREE,
                {{(pvd_pkg::DATA_W-pvd_pkg::DEG_W){1'b0}}, degs[i]});
      send_sample(ONE_Q);
      send_sample(32'hfffe_0000);
      wait_idle();
    end
  endtask

  // a write to an index past the last coefficient changes nothing
  task automatic test_unmapped_index();
    write_reg(REG_UNMAPPED, 32'hdead_beef);
    send_sample(32'h0001_8000);
    wait_idle();
  endtask

  // saturated powers, saturated powers under zero coefficients, saturated sums
  task automatic test_saturation();
    write_reg(pvd_pkg::REG_DEGREE, 32'd5);
    write_all_coefs(WORD_MIN, 0, 0, 0, 0, WORD_MAX);
    send_sample(WORD_MAX);
    send_sample(WORD_MIN);
    wait_idle();
    write_all_coefs(WORD_MIN, 0, 0, 0, 0, 0);
    send_sample(WORD_MAX);
    wait_idle();
    write_reg(pvd_pkg::REG_DEGREE, 32'd1);
    write_all_coefs(WORD_MAX, WORD_MAX, 0, 0, 0, 0);
    send_sample(ONE_Q);
    send_sample(-ONE_Q);
    wait_idle();
  endtask

  // receiver holds off while the sender streams, so the input stalls
  task automatic test_backpressure();
    write_reg(pvd_pkg::REG_DEGREE, 32'd5);
    write_all_coefs(random_coef(), random_coef(), random_coef(),
                    random_coef(), random_coef(), random_coef());
    in_gap_max      = 0;
    out_gap_max     = 0;
    hold_off_cycles = 300;
    repeat (16) send_sample(random_point());
    wait_idle();
    in_gap_max  = 9;
    out_gap_max = 9;
  endtask

  // random settings in phases, with random points and idling on both sides
  task automatic test_random_phases();
    logic [pvd_pkg::DEG_W-1:0] deg;
    for (int phase = 0; phase < 30; phase++) begin
      deg = (phase < 8) ? pvd_pkg::DEG_W'(phase) : pvd_pkg::DEG_W'($urandom_range(0, 7));
      write_reg(pvd_pkg::REG_DEGREE, {{(pvd_pkg::DATA_W-pvd_pkg::DEG_W){1'b0}}, deg});
      write_all_coefs(random_coef(), random_coef(), random_coef(),
                      random_coef(), random_coef(), random_coef());
      in_gap_max  = (phase % 5 == 4) ? 0 : 9;
      out_gap_max = (phase % 5 == 4) ? 0 : 9;
      for (int n = 0; n < 55; n++) begin
        send_sample(random_point());
        // occasionally let everything drain mid-phase
        if (n == 27 && $urandom_range(0, 3) == 0) wait_idle();
      end
      wait_idle();
    end
    in_gap_max  = 9;
    out_gap_max = 9;
  endtask

  // sequence of tests
  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    sample_point_i = '0;
    out_ready_i    = 1'b0;
    degree_mirror  = pvd_pkg::DEGREE_RESET;
    foreach (coef_mirror[k]) coef_mirror[k] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_each_degree();
    test_unmapped_index();
    test_saturation();
    test_backpressure();
    test_random_phases();

    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("checked %0d results over %0d coefficient settings", results_checked,
             settings_count);
    $display("covered degrees 0 to 7, saturation, an unmapped index and long stalls");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
